/* rtl/core/ict_pkg.sv */
// ----------------------------------------------------------------------------
// Idempotent command tracker package
// Shared item layouts, entry record layout and code constants.
// ----------------------------------------------------------------------------
package ict_pkg;

  // Commands carried on the input tuser.
  localparam logic [2:0] CMD_BEGIN    = 3'd0;
  localparam logic [2:0] CMD_COMPLETE = 3'd1;
  localparam logic [2:0] CMD_REJECT   = 3'd2;
  localparam logic [2:0] CMD_FIND     = 3'd3;
  localparam logic [2:0] CMD_EXPIRE   = 3'd4;
  localparam logic [2:0] CMD_CLEAR    = 3'd5;

  // Result codes.
  localparam logic [2:0] RES_OK        = 3'd0;
  localparam logic [2:0] RES_DUPLICATE = 3'd1;
  localparam logic [2:0] RES_MISMATCH  = 3'd2;
  localparam logic [2:0] RES_FULL      = 3'd3;
  localparam logic [2:0] RES_BAD_KEY   = 3'd4;
  localparam logic [2:0] RES_NOT_FOUND = 3'd5;

  // Entry status codes.
  localparam logic [1:0] ST_QUEUED     = 2'd0;
  localparam logic [1:0] ST_APPLIED    = 2'd1;
  localparam logic [1:0] ST_IDEMPOTENT = 2'd2;
  localparam logic [1:0] ST_REJECTED   = 2'd3;

  localparam logic [7:0]  KEY_MAX_LEN = 8'd128;
  localparam logic [31:0] HASH_PRIME  = 32'd16777619;
  localparam logic [31:0] RETENTION_RESET = 32'd60000;

  // Input item payload, first field in the lowest bits.
  typedef struct packed {
    logic [5:0]  pad;
    logic        applied_state;
    logic [7:0]  reason;
    logic        completion_rejected;
    logic [31:0] now_ms;
    logic [31:0] correlation_id;
    logic [31:0] sequence_req;
    logic [7:0]  action;
    logic [7:0]  channel;
    logic [7:0]  key_length;
    logic [31:0] key_hash;
    logic [31:0] session_id;
  } in_t;

  // One stored table entry.
  typedef struct packed {
    logic [31:0] completed_ms;
    logic [31:0] created_ms;
    logic [31:0] resource_seq;
    logic [31:0] expected_seq;
    logic        applied_state;
    logic [7:0]  reason;
    logic [1:0]  status;
    logic [7:0]  action;
    logic [7:0]  channel;
    logic [31:0] correlation;
    logic [31:0] request_hash;
    logic [31:0] key_hash;
    logic [31:0] session;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Result item payload, first field in the lowest bits.
  typedef struct packed {
    logic [1:0]  pad;
    logic [31:0] rec_completed_ms;
    logic [31:0] rec_created_ms;
    logic [31:0] rec_resource_seq;
    logic [31:0] rec_expected_seq;
    logic        rec_applied_state;
    logic [7:0]  rec_reason;
    logic [1:0]  rec_status;
    logic [7:0]  rec_action;
    logic [7:0]  rec_channel;
    logic [31:0] rec_correlation_id;
    logic [31:0] rec_session_id;
    logic [2:0]  result_code;
  } out_t;

  // Per-entry test outcome from the evaluator.
  typedef struct packed {
    logic expire;
    logic match;
  } eval_t;

endpackage

/* rtl/core/ict_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write and one read per cycle on the shared address, read data registered.
// ----------------------------------------------------------------------------
module ict_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic                                 re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] addr_i,
  input  logic [Width-1:0]                     wdata_i,
  output logic [Width-1:0]                     rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

/* rtl/core/ict_eval.sv */
// ----------------------------------------------------------------------------
// Entry evaluator
// Tests one entry read from the table against the current request.
// ----------------------------------------------------------------------------
module ict_eval (
  input  ict_pkg::entry_t entry_i,
  input  logic [2:0]      cmd_i,
  input  logic [31:0]     session_i,
  input  logic [31:0]     key_hash_i,
  input  logic [31:0]     correlation_i,
  input  logic [31:0]     now_ms_i,
  input  logic [31:0]     retention_ms_i,
  output ict_pkg::eval_t  res_o
);

  logic [31:0] age;
  logic        old_done;

  // A completed entry ages out once the wrapped age reaches retention.
  assign age      = now_ms_i - entry_i.completed_ms;
  assign old_done = (entry_i.status != ict_pkg::ST_QUEUED) && (age >= retention_ms_i);

  always_comb begin
    res_o = '0;
    case (cmd_i)
      ict_pkg::CMD_BEGIN: begin
        res_o.expire = old_done;
        res_o.match  = (entry_i.session == session_i) && (entry_i.key_hash == key_hash_i);
      end
      ict_pkg::CMD_COMPLETE, ict_pkg::CMD_REJECT: begin
        res_o.match = (entry_i.correlation == correlation_i);
      end
      ict_pkg::CMD_FIND: begin
        res_o.match = (entry_i.session == session_i) &&
                      (entry_i.correlation == correlation_i);
      end
      ict_pkg::CMD_EXPIRE: begin
        res_o.expire = old_done;
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

endmodule

/* rtl/core/idempotent_command_tracker.sv */
// ----------------------------------------------------------------------------
// Idempotent command tracker
// Table of tracked relay commands with begin, complete, reject, find,
// expire and clear operations.
// ----------------------------------------------------------------------------
// Usage: a request item enters on the s_axis channel, with the command in
// tuser and the request fields in tdata. Begin, complete, reject and find
// return one result item on m_axis; expire and clear return none, and the
// unused command codes are dropped.
// Every table operation walks all TABLE_ENTRIES entries through the single
// RAM read port in S_WALK, one entry a cycle. S_FIN then writes a new or
// updated entry and loads the result register where the command calls for
// them, and the walker returns to S_IDLE. An invalid begin skips the walk
// and goes straight to S_FIN; clear is done in S_IDLE. One item is worked
// on at a time; s_axis_tready is high whenever the walker is idle.
// The result sits in an output register, so a new item is taken while a
// result waits; a stalled receiver holds back only the S_FIN end of the
// next item that returns a result. Reset clears the valid bits (empty
// table) and the output valid and sets retention_ms to 60000. The user must
// write the retention register by cfg_we_i only while the block is idle;
// the block itself does not enforce it.
// ----------------------------------------------------------------------------
module idempotent_command_tracker #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: session_id, key_hash, key_length, channel, action, sequence_req,
  // correlation_id, now_ms, completion_rejected, reason, applied_state, zeros
  input  logic [199:0] s_axis_tdata,
  // tuser: command
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: result_code, rec_session_id, rec_correlation_id, rec_channel,
  // rec_action, rec_status, rec_reason, rec_applied_state, rec_expected_seq,
  // rec_resource_seq, rec_created_ms, rec_completed_ms, zeros
  output logic [223:0] m_axis_tdata
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] LAST_CNT = CW'(TABLE_ENTRIES);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [31:0]           retention_q;
  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;
  ict_pkg::in_t          req_q;
  logic [2:0]            cmd_q;
  logic                  bad_q;
  logic [31:0]           prod_q;
  logic [CW-1:0]         rd_cnt_q;
  logic                  dv_q;
  logic [IW-1:0]         didx_q;
  logic                  hit_q, free_q;
  logic [IW-1:0]         hit_idx_q, free_idx_q;
  ict_pkg::entry_t       hit_e_q;
  logic                  m_valid_q;
  ict_pkg::out_t         m_data_q, m_data_d;

  ict_pkg::in_t          s_in;
  ict_pkg::entry_t       rd_entry, new_entry, upd_entry;
  ict_pkg::eval_t        ev;
  logic [ict_pkg::ENTRY_W-1:0] rdata, wdata;
  logic                  rd_en, wr_en, accept, fin_go, live, emit;
  logic [IW-1:0]         addr;
  logic [31:0]           req_hash;
  logic [1:0]            cmp_status;

  assign s_in          = ict_pkg::in_t'(s_axis_tdata);
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign rd_entry      = ict_pkg::entry_t'(rdata);
  assign req_hash      = {16'd0, req_q.channel, req_q.action} ^ prod_q;
  assign fin_go        = !m_valid_q || m_axis_tready;

  // Entry store.
  ict_ram #(
    .Width (ict_pkg::ENTRY_W),
    .Depth (TABLE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .re_i    (rd_en),
    .addr_i  (addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  ict_eval u_eval (
    .entry_i        (rd_entry),
    .cmd_i          (cmd_q),
    .session_i      (req_q.session_id),
    .key_hash_i     (req_q.key_hash),
    .correlation_i  (req_q.correlation_id),
    .now_ms_i       (req_q.now_ms),
    .retention_ms_i (retention_q),
    .res_o          (ev)
  );

  // Entries written at the end of a begin, a completion or a rejection.
  always_comb begin
    new_entry               = '0;
    new_entry.session       = req_q.session_id;
    new_entry.key_hash      = req_q.key_hash;
    new_entry.request_hash  = req_hash;
    new_entry.correlation   = req_q.correlation_id;
    new_entry.channel       = req_q.channel;
    new_entry.action        = req_q.action;
    new_entry.status        = ict_pkg::ST_QUEUED;
    new_entry.expected_seq  = req_q.sequence_req;
    new_entry.created_ms    = req_q.now_ms;

    if (req_q.completion_rejected) begin
      cmp_status = ict_pkg::ST_REJECTED;
    end else if (hit_e_q.expected_seq == req_q.sequence_req) begin
      cmp_status = ict_pkg::ST_IDEMPOTENT;
    end else begin
      cmp_status = ict_pkg::ST_APPLIED;
    end

    upd_entry              = hit_e_q;
    upd_entry.reason       = req_q.reason;
    upd_entry.completed_ms = req_q.now_ms;
    if (cmd_q == ict_pkg::CMD_COMPLETE) begin
      upd_entry.status        = cmp_status;
      upd_entry.applied_state = req_q.applied_state;
      upd_entry.resource_seq  = req_q.sequence_req;
    end else begin
      upd_entry.status = ict_pkg::ST_REJECTED;
    end
  end

  // Sequencer: walk the table, then finish with a write and a result where the command calls for them.
  always_comb begin
    state_d  = state_q;
    valid_d  = valid_q;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    addr     = rd_cnt_q[IW-1:0];
    wdata    = new_entry;
    emit     = 1'b0;
    m_data_d = '0;
    live     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (s_axis_tuser)
            ict_pkg::CMD_BEGIN: begin
              if (s_in.session_id == 32'd0 || s_in.correlation_id == 32'd0 ||
                  s_in.key_length == 8'd0 || s_in.key_length > ict_pkg::KEY_MAX_LEN) begin
                state_d = S_FIN;
              end else begin
                state_d = S_WALK;
              end
            end
            ict_pkg::CMD_COMPLETE, ict_pkg::CMD_REJECT,
            ict_pkg::CMD_FIND, ict_pkg::CMD_EXPIRE: begin
              state_d = S_WALK;
            end
            ict_pkg::CMD_CLEAR: begin
              valid_d = '0;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_WALK: begin
        rd_en = (rd_cnt_q != LAST_CNT);
        if (dv_q) begin
          if (valid_q[didx_q] && ev.expire) begin
            valid_d[didx_q] = 1'b0;
          end
          live = valid_q[didx_q] && !ev.expire;
          if (didx_q == LAST_IDX) begin
            state_d = S_FIN;
          end
        end
      end

      S_FIN: begin
        if (cmd_q == ict_pkg::CMD_EXPIRE) begin
          state_d = S_IDLE;
        end else if (fin_go) begin
          state_d = S_IDLE;
          emit    = 1'b1;
          if (bad_q) begin
            m_data_d.result_code = ict_pkg::RES_BAD_KEY;
          end else if (cmd_q == ict_pkg::CMD_BEGIN) begin
            if (hit_q) begin
              m_data_d.result_code = (hit_e_q.request_hash == req_hash) ?
                                     ict_pkg::RES_DUPLICATE : ict_pkg::RES_MISMATCH;
              m_data_d = {2'b00, hit_e_q.completed_ms, hit_e_q.created_ms,
                          hit_e_q.resource_seq, hit_e_q.expected_seq,
                          hit_e_q.applied_state, hit_e_q.reason, hit_e_q.status,
                          hit_e_q.action, hit_e_q.channel, hit_e_q.correlation,
                          hit_e_q.session, m_data_d.result_code};
            end else if (free_q) begin
              wr_en   = 1'b1;
              addr    = free_idx_q;
              wdata   = new_entry;
              valid_d[free_idx_q] = 1'b1;
              m_data_d = {2'b00, new_entry.completed_ms, new_entry.created_ms,
                          new_entry.resource_seq, new_entry.expected_seq,
                          new_entry.applied_state, new_entry.reason, new_entry.status,
                          new_entry.action, new_entry.channel, new_entry.correlation,
                          new_entry.session, ict_pkg::RES_OK};
            end else begin
              m_data_d.result_code = ict_pkg::RES_FULL;
            end
          end else if (!hit_q) begin
            m_data_d.result_code = ict_pkg::RES_NOT_FOUND;
          end else if (cmd_q == ict_pkg::CMD_FIND) begin
            m_data_d = {2'b00, hit_e_q.completed_ms, hit_e_q.created_ms,
                        hit_e_q.resource_seq, hit_e_q.expected_seq,
                        hit_e_q.applied_state, hit_e_q.reason, hit_e_q.status,
                        hit_e_q.action, hit_e_q.channel, hit_e_q.correlation,
                        hit_e_q.session, ict_pkg::RES_OK};
          end else begin
            wr_en = 1'b1;
            addr  = hit_idx_q;
            wdata = upd_entry;
            m_data_d = {2'b00, upd_entry.completed_ms, upd_entry.created_ms,
                        upd_entry.resource_seq, upd_entry.expected_seq,
                        upd_entry.applied_state, upd_entry.reason, upd_entry.status,
                        upd_entry.action, upd_entry.channel, upd_entry.correlation,
                        upd_entry.session, ict_pkg::RES_OK};
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      retention_q <= ict_pkg::RETENTION_RESET;
      rd_cnt_q    <= '0;
      dv_q        <= 1'b0;
      didx_q      <= '0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      if (cfg_we_i) begin
        retention_q <= cfg_wdata_i;
      end
      if (accept) begin
        rd_cnt_q <= '0;
        hit_q    <= 1'b0;
        free_q   <= 1'b0;
      end else if (rd_en) begin
        rd_cnt_q <= rd_cnt_q + CW'(1);
      end
      dv_q   <= rd_en;
      didx_q <= rd_cnt_q[IW-1:0];
      if (state_q == S_WALK && dv_q) begin
        if (live && ev.match && !hit_q) begin
          hit_q <= 1'b1;
        end
        if (!live && !free_q) begin
          free_q <= 1'b1;
        end
      end
      if (emit) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers. Only a begin can be rejected for its ids or key.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= s_in;
      cmd_q  <= s_axis_tuser;
      bad_q  <= (s_axis_tuser == ict_pkg::CMD_BEGIN) &&
                ((s_in.session_id == 32'd0) || (s_in.correlation_id == 32'd0) ||
                 (s_in.key_length == 8'd0) || (s_in.key_length > ict_pkg::KEY_MAX_LEN));
      prod_q <= s_in.sequence_req * ict_pkg::HASH_PRIME;
    end
    if (state_q == S_WALK && dv_q) begin
      if (live && ev.match && !hit_q) begin
        hit_idx_q <= didx_q;
        hit_e_q   <= rd_entry;
      end
      if (!live && !free_q) begin
        free_idx_q <= didx_q;
      end
    end
    if (emit) begin
      m_data_q <= m_data_d;
    end
  end

endmodule

/* rtl/core/ict_checker.sv */
// ----------------------------------------------------------------------------
// Idempotent command tracker port checker
// Watches the result channel of the top level over time.
// ----------------------------------------------------------------------------
module ict_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [223:0] m_axis_tdata
);

  // Result codes stay within the defined set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[2:0] <= ict_pkg::RES_NOT_FOUND))
    else $error("result code out of range");

  // Failures without a record carry an all-zero record.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[2:0] == ict_pkg::RES_FULL ||
     m_axis_tdata[2:0] == ict_pkg::RES_BAD_KEY ||
     m_axis_tdata[2:0] == ict_pkg::RES_NOT_FOUND)) |-> (m_axis_tdata[221:3] == '0))
    else $error("record present on a failure result");

  // Any returned entry was created with a nonzero session.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[2:0] == ict_pkg::RES_OK ||
     m_axis_tdata[2:0] == ict_pkg::RES_DUPLICATE ||
     m_axis_tdata[2:0] == ict_pkg::RES_MISMATCH)) |-> (m_axis_tdata[34:3] != 32'd0))
    else $error("returned entry has zero session");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind idempotent_command_tracker ict_checker u_ict_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
